// ===== design/bmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_pkg: shared types and constants for belief mass conditioning
// Value widths, request codes, divider interface structs and helpers.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int DEF_MAX_FRAME_BITS = 8;
  localparam int IDX_W  = 8;   // subset index width
  localparam int MASS_W = 16;  // Q0.16 mass
  localparam int VAL_W  = 24;  // Q8.16 bin and result
  localparam int FRAC_W = 16;
  localparam int FB_W   = 4;   // frame_bits register width

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // request codes carried on in_tuser
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_FRAME_BITS = 1'b0;
  localparam logic CFG_COND_MASK  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

  // saturating add of two bin values
  function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
  endfunction

  // low-bit mask for the effective frame width
  function automatic logic [IDX_W-1:0] idx_mask(logic [FB_W-1:0] fb, int max_bits);
    int n;
    n = int'(fb);
    if (n < 1) n = 1;
    if (n > max_bits) n = max_bits;
    if (n >= IDX_W) return {IDX_W{1'b1}};
    return IDX_W'((1 << n) - 1);
  endfunction

endpackage
`default_nettype wire

// ===== design/bmc_bin_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_bin_ram: bin storage
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmc_bin_ram #(
  parameter int AW = 8,
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/bmc_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_divider: iterative Q8.16 divider
// Computes (dividend << 16) / divisor one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module bmc_divider
  import bmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int SH    = VAL_W - FRAC_W;
  localparam int CNT_W = $clog2(VAL_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VAL_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] sh_r, sh_nxt;
  logic [VAL_W-1:0] dvs_r, dvs_nxt;

  logic             ovf;
  logic [VAL_W:0]   r2;
  logic [VAL_W+1:0] trial;

  // quotient above range when dividend >= divisor << SH
  assign ovf = ({{SH{1'b0}}, req.dividend} >= {req.divisor, {SH{1'b0}}});

  // one restoring step: shift in next dividend bit, try subtract
  assign r2    = {rem_r, sh_r[VAL_W-1]};
  assign trial = {1'b0, r2} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      if (ovf) begin
        sh_nxt   = VAL_MAX;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = VAL_W'(req.dividend >> SH);
        sh_nxt   = {req.dividend[SH-1:0], {FRAC_W{1'b0}}};
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!trial[VAL_W+1]) begin
        rem_nxt = trial[VAL_W-1:0];
        sh_nxt  = {sh_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = r2[VAL_W-1:0];
        sh_nxt  = {sh_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = sh_r;

endmodule
`default_nettype wire

// ===== design/belief_mass_conditioning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// belief_mass_conditioning: conditioned belief mass store
// Bins masses by subset AND cond_mask; reads return raw or normalized bins.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : requests; in_tuser = request kind (clear, load, read),
//           in_tdata = {mass, subset_index}. One request at a time.
//   out_* : one result per read; out_tdata = {cond_value, subset_out},
//           out_tuser = {zero_divisor, was_normalized}.
//   cfg_* : register writes, index 0 frame_bits, index 1 cond_mask; always
//           ready, write only while no request is in progress.
// Request handling
//   load : read-modify-write of one bin in the memory
//   read : a normalized read may divide; a saturating quotient skips the steps;
//          the divider produces one quotient bit per cycle, 24 steps
//   clear: all 2^MAX_FRAME_BITS rows, one memory row written per cycle
// Reset: a clearing sweep over all 2^MAX_FRAME_BITS rows zeroes the bins;
//   in_tready stays low meanwhile, cfg writes are still taken.
// Stall: a finished result waits in the output register; the block keeps
//   taking loads and clears, and a following read holds until it drains.
// ----------------------------------------------------------------------------
module belief_mass_conditioning
  import bmc_pkg::*;
#(
  parameter int MAX_FRAME_BITS = DEF_MAX_FRAME_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] subset_index, [23:8] mass
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [7:0] subset_out, [31:8] cond_value
  output logic [1:0]       out_tuser,  // [0] was_normalized, [1] zero_divisor
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW   = MAX_FRAME_BITS;
  localparam int EXTW = (AW > IDX_W) ? AW : IDX_W;

  localparam logic [2:0] S_CLR     = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_LD_WR   = 3'd2;
  localparam logic [2:0] S_RD_WAIT = 3'd3;
  localparam logic [2:0] S_DIV     = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic [FB_W-1:0]  frame_bits_r;
  logic [IDX_W-1:0] cond_mask_r;
  logic [VAL_W-1:0] total_r, total_nxt;
  logic [VAL_W-1:0] empty_r, empty_nxt;
  logic [AW-1:0]    bin_addr_r, bin_addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [MASS_W-1:0] mass_r, mass_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             res_norm_r, res_norm_nxt;
  logic             res_zdiv_r, res_zdiv_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [1:0]       out_user_r, out_user_nxt;

  logic [IDX_W-1:0] in_idx;
  logic [MASS_W-1:0] in_mass;
  logic [EXTW-1:0]  idx_ext, load_ext;
  logic [VAL_W-1:0] ld_sum;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // request fields, index limited to the effective frame width
  assign in_idx   = in_tdata[IDX_W-1:0] & idx_mask(frame_bits_r, MAX_FRAME_BITS);
  assign in_mass  = in_tdata[IDX_W +: MASS_W];
  assign idx_ext  = EXTW'(in_idx);
  assign load_ext = EXTW'(in_idx & cond_mask_r);
  assign ld_sum   = sat_add(ram_rdata, VAL_W'(mass_r));

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r <= FB_W'(8);
      cond_mask_r  <= {IDX_W{1'b1}};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_BITS: frame_bits_r <= cfg_data[FB_W-1:0];
        CFG_COND_MASK:  cond_mask_r  <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    total_nxt     = total_r;
    empty_nxt     = empty_r;
    bin_addr_nxt  = bin_addr_r;
    idx_nxt       = idx_r;
    mass_nxt      = mass_r;
    res_val_nxt   = res_val_r;
    res_norm_nxt  = res_norm_r;
    res_zdiv_nxt  = res_zdiv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = bin_addr_r;
    ram_wdata     = ld_sum;
    ram_re        = 1'b0;
    ram_raddr     = idx_ext[AW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = ram_rdata;
    div_req.divisor  = total_r - empty_r;

    // output register drains
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            REQ_CLEAR: begin
              total_nxt    = '0;
              empty_nxt    = '0;
              clr_addr_nxt = '0;
              state_nxt    = S_CLR;
            end
            REQ_LOAD: begin
              ram_re       = 1'b1;
              ram_raddr    = load_ext[AW-1:0];
              bin_addr_nxt = load_ext[AW-1:0];
              mass_nxt     = in_mass;
              if (in_idx != '0) begin
                total_nxt = sat_add(total_r, VAL_W'(in_mass));
              end
              state_nxt = S_LD_WR;
            end
            REQ_READ: begin
              ram_re    = 1'b1;
              ram_raddr = idx_ext[AW-1:0];
              idx_nxt   = in_idx;
              state_nxt = S_RD_WAIT;
            end
            default: ;
          endcase
        end
      end
      S_LD_WR: begin
        ram_we = 1'b1;
        if (bin_addr_r == '0) begin
          empty_nxt = ld_sum;
        end
        state_nxt = S_IDLE;
      end
      S_RD_WAIT: begin
        res_zdiv_nxt = 1'b0;
        if (empty_r == '0) begin
          res_val_nxt  = ram_rdata;
          res_norm_nxt = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          res_norm_nxt = 1'b1;
          res_val_nxt  = '0;
          if (total_r <= empty_r) begin
            res_zdiv_nxt = 1'b1;
            state_nxt    = S_OUT;
          end else if (idx_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_val_nxt = div_rsp.quotient;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_val_r, idx_r};
          out_user_nxt  = {res_zdiv_r, res_norm_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      total_r     <= '0;
      empty_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      total_r     <= total_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bin_addr_r <= bin_addr_nxt;
    idx_r      <= idx_nxt;
    mass_r     <= mass_nxt;
    res_val_r  <= res_val_nxt;
    res_norm_r <= res_norm_nxt;
    res_zdiv_r <= res_zdiv_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // bin memory
  bmc_bin_ram #(
    .AW (AW),
    .DW (VAL_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider for normalized reads
  bmc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // zero divisor is only reported on the normalizing branch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] || !out_tuser[1]))
    else $error("zero_divisor without normalization");

  // normalized read of the empty set returns zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0] && out_tdata[7:0] == 8'd0) |-> out_tdata[31:8] == '0)
    else $error("normalized empty-set read not zero");

  // a clear request zeroes total and empty-set bin
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_CLEAR) |=> (total_r == '0 && empty_r == '0))
    else $error("clear left mass behind");

  // division only runs with a positive divisor
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (empty_r != '0 && total_r > empty_r))
    else $error("division with non-positive divisor");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: belief mass conditioning testbench
// Drives clear, load and read requests with random gaps and result stalls.
// A local copy of the bins predicts each read, and every field is checked.
// ----------------------------------------------------------------------------
module tb;
  import bmc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int BINS            = 1 << DEF_MAX_FRAME_BITS;
  localparam int RANDOM_REQUESTS = 1950;
  localparam int PHASE_REQUESTS  = 150;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int SETTLE_CYCLES   = 300;  // covers a full clear sweep
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 40;

  typedef struct packed {
    logic [IDX_W-1:0] subset;
    logic [VAL_W-1:0] value;
    logic             normalized;
    logic             zero_div;
  } read_result_t;

  // bin store predictor and result checker
  class conditioning_scoreboard;
    logic [VAL_W-1:0] bin_mass [BINS];
    logic [VAL_W-1:0] mass_sum;
    logic [FB_W-1:0]  frame_bits;
    logic [7:0]       cond_mask;
    read_result_t     expected_reads [$];
    int               mismatches;

    function new();
      foreach (bin_mass[i]) bin_mass[i] = '0;
      mass_sum   = '0;
      frame_bits = 4'd8;
      cond_mask  = 8'hFF;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    function logic [VAL_W-1:0] add_clamped(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      int unsigned s;
      s = int'(a) + int'(b);
      if (s > int'(VAL_MAX)) return VAL_MAX;
      return VAL_W'(s);
    endfunction

    // effective subset bits: width clamped to 1..max
    function logic [IDX_W-1:0] subset_bits();
      int n;
      n = int'(frame_bits);
      if (n < 1) n = 1;
      if (n > DEF_MAX_FRAME_BITS) n = DEF_MAX_FRAME_BITS;
      return IDX_W'((1 << n) - 1);
    endfunction

    function void write_reg(logic index, logic [7:0] data);
      if (index == CFG_FRAME_BITS) frame_bits = data[FB_W-1:0];
      else cond_mask = data;
    endfunction

    // apply one accepted request, queue the read result it causes
    function void note_request(logic [1:0] req, logic [7:0] subset, logic [15:0] mass);
      logic [IDX_W-1:0] idx;
      logic [IDX_W-1:0] dest;
      logic [VAL_W-1:0] bin;
      logic [VAL_W-1:0] empty;
      longint unsigned  num;
      longint unsigned  quotient;
      read_result_t     r;
      idx = subset & subset_bits();
      case (req)
        REQ_CLEAR: begin
          foreach (bin_mass[i]) bin_mass[i] = '0;
          mass_sum = '0;
        end
        REQ_LOAD: begin
          dest = idx & cond_mask;
          bin_mass[dest] = add_clamped(bin_mass[dest], VAL_W'(mass));
          if (idx != 0) mass_sum = add_clamped(mass_sum, VAL_W'(mass));
        end
        REQ_READ: begin
          bin   = bin_mass[idx];
          empty = bin_mass[0];
          r.subset     = idx;
          r.value      = bin;
          r.normalized = 1'b0;
          r.zero_div   = 1'b0;
          // positive empty-set bin: normalize by total minus empty bin
          if (empty != 0) begin
            r.normalized = 1'b1;
            if (mass_sum <= empty) begin
              r.zero_div = 1'b1;
              r.value    = '0;
            end else begin
              num      = bin;
              num      = num << FRAC_W;
              quotient = num / longint'(mass_sum - empty);
              r.value  = (quotient > VAL_MAX) ? VAL_MAX : VAL_W'(quotient);
            end
            if (idx == 0) r.value = '0;
          end
          expected_reads = {expected_reads, r};
        end
        default: ;
      endcase
    endfunction

    task check_read(logic [31:0] tdata, logic [1:0] tuser);
      read_result_t want;
      if (expected_reads.size() == 0) begin
        report_mismatch($sformatf("result with no read pending, tdata %h", tdata));
        return;
      end
      want = expected_reads.pop_front();
      if (tdata[7:0] != want.subset)
        report_mismatch($sformatf("subset_out %h, expected %h", tdata[7:0], want.subset));
      if (tdata[31:8] != want.value)
        report_mismatch($sformatf("cond_value %h, expected %h (subset %h)",
                                  tdata[31:8], want.value, want.subset));
      if (tuser[0] != want.normalized)
        report_mismatch($sformatf("was_normalized %b, expected %b (subset %h)",
                                  tuser[0], want.normalized, want.subset));
      if (tuser[1] != want.zero_div)
        report_mismatch($sformatf("zero_divisor %b, expected %b (subset %h)",
                                  tuser[1], want.zero_div, want.subset));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [7:0] subset_index, [23:8] mass
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [7:0] subset_out, [31:8] cond_value
  logic [1:0]  out_tuser;  // [0] was_normalized, [1] zero_divisor
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  conditioning_scoreboard sb;
  int idle_cycles;
  int requests_done;
  bit sender_burst;
  bit receiver_burst;
  bit hold_off_req;

  belief_mass_conditioning dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one request, with a random gap before it; valid stays high after it
  task automatic send_request(logic [1:0] req, logic [7:0] subset, logic [15:0] mass);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {mass, subset};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, subset, mass);
    if (req != REQ_UNUSED) requests_done++;
  endtask

  task automatic write_reg(logic index, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
  endtask

  // wait for the block to go idle, then write both registers
  task automatic set_config(logic [3:0] fb, logic [7:0] mask);
    logic [7:0] fb_data;
    in_tvalid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fb_data = {4'($urandom), fb};
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_FRAME_BITS, fb_data);
      write_reg(CFG_COND_MASK, mask);
    end else begin
      write_reg(CFG_COND_MASK, mask);
      write_reg(CFG_FRAME_BITS, fb_data);
    end
    cfg_valid <= 1'b0;
  endtask

  // one random sequence: mostly clear, loads, reads of loaded subsets
  task automatic run_scenario(int scenario_no);
    int         kind;
    int         n;
    int         i;
    logic [1:0] req;
    logic [7:0] idx;
    logic [15:0] mass;
    logic [7:0] loaded [$];
    kind = (scenario_no == 3) ? 0 : $urandom_range(0, 79);
    sender_burst = ($urandom_range(0, 5) == 0);
    if (kind == 0) begin
      // flood one bin past saturation
      sender_burst = 1'b1;
      send_request(REQ_CLEAR, 8'($urandom), 16'($urandom));
      idx = 8'($urandom);
      n = $urandom_range(258, 270);
      for (i = 0; i < n; i++) send_request(REQ_LOAD, idx, 16'hFFFF);
      if ($urandom_range(0, 1) == 0) send_request(REQ_LOAD, 8'h00, 16'($urandom));
      send_request(REQ_READ, idx, 16'($urandom));
      send_request(REQ_READ, 8'h00, 16'($urandom));
      send_request(REQ_READ, 8'($urandom), 16'($urandom));
    end else if (kind < 12) begin
      // noise: any request code, clears kept rare
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        req = 2'($urandom);
        if (req == REQ_CLEAR && $urandom_range(0, 3) != 0) req = REQ_READ;
        send_request(req, 8'($urandom), 16'($urandom));
      end
    end else begin
      if ($urandom_range(0, 9) < 7) send_request(REQ_CLEAR, 8'($urandom), 16'($urandom));
      n = $urandom_range(1, 16);
      for (i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       idx = 8'h00;
          1:       idx = 8'($urandom) & ~sb.cond_mask;  // lands in the empty-set bin
          default: idx = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0:       mass = 16'h0000;
          1:       mass = 16'hFFFF;
          2:       mass = 16'($urandom_range(1, 15));
          default: mass = 16'($urandom);
        endcase
        loaded = {loaded, idx};
        send_request(REQ_LOAD, idx, mass);
      end
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        idx = ($urandom_range(0, 2) != 0) ? loaded[$urandom_range(0, loaded.size() - 1)]
                                          : 8'($urandom);
        send_request(REQ_READ, idx, 16'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    int phase;
    int scenario_no;
    int item_goal;
    int phase_end;
    int i;
    logic [3:0] fb;
    logic [7:0] mask;
    sb = new();
    requests_done  = 0;
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
    hold_off_req   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_CLEAR;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FRAME_BITS;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, raw values, normalization, zero divisor
    set_config(4'd8, 8'hFF);
    send_request(REQ_READ,   8'h00, 16'h0000);
    send_request(REQ_LOAD,   8'hFF, 16'hFFFF);
    send_request(REQ_LOAD,   8'h01, 16'h0000);
    send_request(REQ_READ,   8'hFF, 16'hFFFF);
    send_request(REQ_UNUSED, 8'h55, 16'h1234);
    send_request(REQ_LOAD,   8'h00, 16'h8000);
    send_request(REQ_READ,   8'hFF, 16'h0000);
    send_request(REQ_READ,   8'h00, 16'h0000);
    send_request(REQ_LOAD,   8'h00, 16'hFFFF);
    send_request(REQ_READ,   8'hFF, 16'h0000);
    send_request(REQ_READ,   8'h00, 16'h0000);
    send_request(REQ_CLEAR,  8'hAA, 16'h5555);
    send_request(REQ_READ,   8'hFF, 16'h0000);
    // divisor of one: quotient saturates
    send_request(REQ_LOAD,   8'h80, 16'hFFFF);
    send_request(REQ_LOAD,   8'h00, 16'hFFFE);
    send_request(REQ_READ,   8'h80, 16'h0000);
    send_request(REQ_READ,   8'h3F, 16'h0000);
    // new frame and mask, bins loaded earlier keep their binning
    set_config(4'd3, 8'h05);
    send_request(REQ_READ,   8'hF8, 16'h0000);
    send_request(REQ_LOAD,   8'h07, 16'h1000);
    send_request(REQ_READ,   8'h0D, 16'h0000);

    // random phases, each under its own register setting
    item_goal   = requests_done + RANDOM_REQUESTS;
    phase       = 0;
    scenario_no = 0;
    while (requests_done < item_goal) begin
      case (phase)
        0:       begin fb = 4'd1;  mask = 8'h01; end
        1:       begin fb = 4'd0;  mask = 8'hFF; end
        2:       begin fb = 4'd15; mask = 8'hAA; end
        3:       begin fb = 4'd2;  mask = 8'h02; end
        4:       begin fb = 4'd4;  mask = 8'h0B; end
        5:       begin fb = 4'd8;  mask = 8'h00; end
        6:       begin fb = 4'd9;  mask = 8'h80; end
        7:       begin fb = 4'd5;  mask = 8'h1F; end
        8:       begin fb = 4'd8;  mask = 8'hFF; end
        default: begin fb = 4'($urandom); mask = 8'($urandom); end
      endcase
      set_config(fb, mask);
      // long result hold-off while reads keep coming
      if (phase == 2) begin
        hold_off_req = 1'b1;
        sender_burst = 1'b1;
        send_request(REQ_LOAD, 8'h00, 16'h0100);
        for (i = 0; i < 12; i++) begin
          send_request(REQ_LOAD, 8'($urandom), 16'($urandom));
          send_request(REQ_READ, 8'($urandom), 16'($urandom));
        end
      end
      phase++;
      phase_end = requests_done + PHASE_REQUESTS;
      while (requests_done < phase_end && requests_done < item_goal) begin
        run_scenario(scenario_no);
        scenario_no++;
      end
    end

    // drain and finish
    in_tvalid <= 1'b0;
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) receiver_burst = ~receiver_burst;
      stall = receiver_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_read(out_tdata, out_tuser);
  end

  // watchdog on cycles with no request, result or register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
design/bmc_pkg.sv
design/bmc_bin_ram.sv
design/bmc_divider.sv
design/belief_mass_conditioning.sv
dv/tb.sv
